[hdl/sampled_gradient_estimator_top_defines.svh]
// assertion macros for the sampled gradient estimator checker
// no dependencies; taken in by the checker through an include
`ifndef SAMPLED_GRADIENT_ESTIMATOR_TOP_DEFINES_SVH
`define SAMPLED_GRADIENT_ESTIMATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SGE_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sge check failed: same-cycle rule");

// next-cycle implication, disabled while reset is asserted
`define SGE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sge check failed: next-cycle rule");

`endif

[hdl/sge_pkg.sv]
// shared constants and control types of the sampled gradient estimator
// no dependencies; used by controller, datapath and top level
package sge_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // controller to datapath commands
  typedef struct packed {
    logic load;        // capture the incoming sample
    logic setup;       // form differences for one slope
    logic sel_older;   // use the sample two back instead of the previous one
    logic step;        // one divider iteration
    logic emit;        // write a slope result
    logic emit_err;    // write a too-few-points result
    logic last_slope;  // tag the written slope as final of the series
    logic shift;       // move the sample history along
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;    // output register can take a result this cycle
  } status_t;

endpackage

[hdl/sge_in_if.sv]
// input channel of the sampled gradient estimator: one (x, y) sample per item
// depends on sge_pkg for the default width
interface sge_in_if #(
  parameter int unsigned DATA_WIDTH = sge_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] x_value;
  logic signed [DATA_WIDTH-1:0] y_value;
  logic                         last_point;

  modport source (output valid, output x_value, output y_value, output last_point,
                  input ready);
  modport sink   (input valid, input x_value, input y_value, input last_point,
                  output ready);
endinterface

[hdl/sge_out_if.sv]
// output channel of the sampled gradient estimator: one slope per item
// depends on sge_pkg for the default width
interface sge_out_if #(
  parameter int unsigned DATA_WIDTH = sge_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] slope;
  logic                         zero_span;
  logic                         too_few;
  logic                         last_slope;

  modport source (output valid, output slope, output zero_span, output too_few,
                  output last_slope, input ready);
  modport sink   (input valid, input slope, input zero_span, input too_few,
                  input last_slope, output ready);
endinterface

[hdl/sampled_gradient_estimator_top.sv]
// top level of the sampled gradient estimator: controller plus datapath
// depends on sge_pkg, sge_in_if, sge_out_if, sge_ctrl and sge_datapath
// a sample that closes no slope only shifts the history, a too-short series end writes an
//   error result; each slope is formed by the radix-2 divider
// the block takes one sample at a time and gives none, an error, one or two slopes for it;
//   a result is held back until the output register is free; reset: async active
//   low, clears history, point count and output valid
module sampled_gradient_estimator_top #(
  parameter int unsigned DATA_WIDTH = sge_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = sge_pkg::FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sge_in_if.sink    in_i,
  sge_out_if.source out_o
);

  // command and status bundles between the two halves
  sge_pkg::cmd_t    cmd;
  sge_pkg::status_t status;

  // controller: one item at a time, walks setup, divide steps and result write
  // per slope, then shifts the sample history
  sge_ctrl #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last_point),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: holds the two previous samples, forms |dy| << FRAC_BITS / |dx|
  // one quotient bit a cycle, saturates and signs it; the output register
  // lets the next sample in while a result still waits downstream
  sge_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .in_x_i           (in_i.x_value),
    .in_y_i           (in_i.y_value),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .out_slope_o      (out_o.slope),
    .out_zero_span_o  (out_o.zero_span),
    .out_too_few_o    (out_o.too_few),
    .out_last_slope_o (out_o.last_slope)
  );

endmodule

[hdl/sge_ctrl.sv]
// controller of the sampled gradient estimator: sequences setup, divide and write
// depends on sge_pkg for command and status types
module sge_ctrl #(
  parameter int unsigned DATA_WIDTH = sge_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = sge_pkg::FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  input  sge_pkg::status_t status_i,
  output sge_pkg::cmd_t    cmd_o
);

  localparam int unsigned Steps = DATA_WIDTH + FRAC_BITS;
  localparam int unsigned CntW  = $clog2(Steps);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSetup = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StFin   = 3'd3;
  localparam logic [2:0] StErr   = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      ps_q, ps_d;
  logic            last_q, last_d;
  logic            two_q, two_d;
  logic            sel_older_q, sel_older_d;
  logic            job_last_q, job_last_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ps_d        = ps_q;
    last_d      = last_q;
    two_d       = two_q;
    sel_older_d = sel_older_q;
    job_last_d  = job_last_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          last_d     = in_last_i;
          job_last_d = 1'b0;
          if (in_last_i) begin
            if (ps_q inside {2'd0, 2'd1}) begin
              state_d = StErr;
            end else begin
              two_d       = 1'b1;
              sel_older_d = 1'b1;
              state_d     = StSetup;
            end
          end else if (ps_q == 2'd0) begin
            state_d = StDone;
          end else begin
            two_d       = 1'b0;
            sel_older_d = (ps_q != 2'd1);
            state_d     = StSetup;
          end
        end
      end
      StSetup: begin
        cmd_o.setup     = 1'b1;
        cmd_o.sel_older = sel_older_q;
        cnt_d           = '0;
        state_d         = StDiv;
      end
      StDiv: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == CntW'(Steps - 1)) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (status_i.out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.last_slope = job_last_q;
          if (two_q) begin
            two_d       = 1'b0;
            sel_older_d = 1'b0;
            job_last_d  = 1'b1;
            state_d     = StSetup;
          end else begin
            state_d = StDone;
          end
        end
      end
      StErr: begin
        if (status_i.out_free) begin
          cmd_o.emit_err = 1'b1;
          state_d        = StDone;
        end
      end
      StDone: begin
        cmd_o.shift = 1'b1;
        if (last_q) begin
          ps_d = 2'd0;
        end else if (ps_q != 2'd3) begin
          ps_d = ps_q + 2'd1;
        end
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      ps_q        <= 2'd0;
      last_q      <= 1'b0;
      two_q       <= 1'b0;
      sel_older_q <= 1'b0;
      job_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ps_q        <= ps_d;
      last_q      <= last_d;
      two_q       <= two_d;
      sel_older_q <= sel_older_d;
      job_last_q  <= job_last_d;
    end
  end

endmodule

[hdl/sge_datapath.sv]
// datapath of the sampled gradient estimator: sample history, differences,
// radix-2 restoring divider, saturation and output register; uses sge_pkg
module sge_datapath #(
  parameter int unsigned DATA_WIDTH = sge_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = sge_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sge_pkg::cmd_t         cmd_i,
  output sge_pkg::status_t      status_o,
  input  logic [DATA_WIDTH-1:0] in_x_i,
  input  logic [DATA_WIDTH-1:0] in_y_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DATA_WIDTH-1:0] out_slope_o,
  output logic                  out_zero_span_o,
  output logic                  out_too_few_o,
  output logic                  out_last_slope_o
);

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned QW = DATA_WIDTH + FRAC_BITS;

  localparam logic [W-1:0] MaxPos = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MinNeg = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0]  cur_x_q, cur_y_q;
  logic [W-1:0]  older_x_q, older_y_q, newer_x_q, newer_y_q;
  logic [W-1:0]  mx_q, rem_q;
  logic [QW-1:0] dq_q;
  logic          nx_q, ny_q, my_zero_q;

  // differences against the chosen earlier sample
  logic [W-1:0] base_x, base_y;
  logic [W:0]   dx, dy;
  logic [W-1:0] mx, my;

  assign base_x = cmd_i.sel_older ? older_x_q : newer_x_q;
  assign base_y = cmd_i.sel_older ? older_y_q : newer_y_q;
  assign dx = {cur_x_q[W-1], cur_x_q} - {base_x[W-1], base_x};
  assign dy = {cur_y_q[W-1], cur_y_q} - {base_y[W-1], base_y};
  assign mx = dx[W] ? W'(-dx) : dx[W-1:0];
  assign my = dy[W] ? W'(-dy) : dy[W-1:0];

  // one restoring divide step
  logic [W:0]   rem_sh, rem_sub;
  logic         q_bit;

  assign rem_sh  = {rem_q, dq_q[QW-1]};
  assign rem_sub = rem_sh - {1'b0, mx_q};
  assign q_bit   = (rem_sh >= {1'b0, mx_q});

  // saturation and sign
  logic         neg;
  logic [W-1:0] lim, q_sat, slope_val;
  logic         over;

  assign neg   = (nx_q != ny_q) && !my_zero_q;
  assign lim   = neg ? MinNeg : MaxPos;
  assign over  = (dq_q > QW'(lim));
  assign q_sat = over ? lim : dq_q[W-1:0];

  always_comb begin
    if (mx_q == '0) begin
      if (my_zero_q) begin
        slope_val = '0;
      end else if (ny_q) begin
        slope_val = MinNeg;
      end else begin
        slope_val = MaxPos;
      end
    end else begin
      slope_val = neg ? W'(-q_sat) : q_sat;
    end
  end

  logic out_valid_q;

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      older_x_q   <= '0;
      older_y_q   <= '0;
      newer_x_q   <= '0;
      newer_y_q   <= '0;
    end else begin
      if (cmd_i.emit || cmd_i.emit_err) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.shift) begin
        older_x_q <= newer_x_q;
        older_y_q <= newer_y_q;
        newer_x_q <= cur_x_q;
        newer_y_q <= cur_y_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_x_q <= in_x_i;
      cur_y_q <= in_y_i;
    end
    if (cmd_i.setup) begin
      mx_q      <= mx;
      nx_q      <= dx[W];
      ny_q      <= dy[W];
      my_zero_q <= (my == '0);
      rem_q     <= '0;
      dq_q      <= QW'(my) << FRAC_BITS;
    end else if (cmd_i.step) begin
      rem_q <= q_bit ? rem_sub[W-1:0] : rem_sh[W-1:0];
      dq_q  <= {dq_q[QW-2:0], q_bit};
    end
    if (cmd_i.emit) begin
      out_slope_o      <= slope_val;
      out_zero_span_o  <= (mx_q == '0);
      out_too_few_o    <= 1'b0;
      out_last_slope_o <= cmd_i.last_slope;
    end else if (cmd_i.emit_err) begin
      out_slope_o      <= '0;
      out_zero_span_o  <= 1'b0;
      out_too_few_o    <= 1'b1;
      out_last_slope_o <= 1'b1;
    end
  end

endmodule

[hdl/sge_checker.sv]
// port-level checks of the sampled gradient estimator, bound to the top level
// depends on sge_pkg and sampled_gradient_estimator_top_defines.svh
`include "sampled_gradient_estimator_top_defines.svh"

module sge_checker #(
  parameter int unsigned DATA_WIDTH = sge_pkg::DATA_WIDTH_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [DATA_WIDTH-1:0] out_slope_i,
  input logic                  out_zero_span_i,
  input logic                  out_too_few_i,
  input logic                  out_last_slope_i
);

  localparam logic [DATA_WIDTH-1:0] MaxPos = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MinNeg = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // a waiting result is not withdrawn
  `SGE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // a taken sample leaves the block busy in the next cycle
  `SGE_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // a short series ends with a zero, final, non-span result
  `SGE_ASSERT_NOW(a_too_few_fields, clk_i, rst_ni, out_valid_i && out_too_few_i, out_last_slope_i && (out_slope_i == '0) && !out_zero_span_i)

  // a zero x-span gives zero or a limit value
  `SGE_ASSERT_NOW(a_zero_span_value, clk_i, rst_ni, out_valid_i && out_zero_span_i, (out_slope_i == '0) || (out_slope_i == MaxPos) || (out_slope_i == MinNeg))

endmodule

bind sampled_gradient_estimator_top sge_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_sge_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_slope_i      (out_o.slope),
  .out_zero_span_i  (out_o.zero_span),
  .out_too_few_i    (out_o.too_few),
  .out_last_slope_i (out_o.last_slope)
);
